>>> sv/recursive_mutex_fifo_handoff_assert.svh
// ----------------------------------------------------------------------------
// Recursive mutex assertion macros
// Shared forms for the concurrent checks on the mutex ports.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_ASSERT_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_ASSERT_SVH

// check a property outside reset
`define RMFH_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rmfh: port property failed");

// check a property at every edge, reset included
`define RMFH_CHECK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("rmfh: reset property failed");

`endif

>>> sv/rmfh_pkg.sv
// ----------------------------------------------------------------------------
// Recursive mutex package
// Sizes, payload types, status codes and queue slot arithmetic.
// ----------------------------------------------------------------------------
package rmfh_pkg;

    localparam int TASK_COUNT  = 64;
    localparam int DEPTH_BITS  = 8;
    localparam int ID_W        = 6;
    localparam int STATUS_W    = 4;
    localparam int DEPTH_OUT_W = 8;
    localparam int WAIT_OUT_W  = 7;
    localparam int PTR_W       = $clog2(TASK_COUNT);
    localparam int FILL_W      = $clog2(TASK_COUNT + 1);

    typedef logic [ID_W-1:0]        t_id;
    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [FILL_W-1:0]      t_fill;
    typedef logic [DEPTH_BITS-1:0]  t_depth;
    typedef logic [STATUS_W-1:0]    t_status;
    typedef logic [DEPTH_OUT_W-1:0] t_depth_out;
    typedef logic [WAIT_OUT_W-1:0]  t_wait_out;

    localparam t_depth DEPTH_MAX = '1;
    localparam t_fill  FILL_FULL = t_fill'(TASK_COUNT);

    localparam logic FUNC_LOCK   = 1'b0;
    localparam logic FUNC_UNLOCK = 1'b1;

    localparam t_status ST_ACQUIRED  = t_status'(0);
    localparam t_status ST_NESTED    = t_status'(1);
    localparam t_status ST_QUEUED    = t_status'(2);
    localparam t_status ST_QFULL     = t_status'(3);
    localparam t_status ST_SATURATED = t_status'(4);
    localparam t_status ST_PARTIAL   = t_status'(5);
    localparam t_status ST_FREED     = t_status'(6);
    localparam t_status ST_HANDOFF   = t_status'(7);
    localparam t_status ST_NOT_OWNER = t_status'(8);

    function automatic t_ptr ptr_next(t_ptr p);
        return (p == t_ptr'(TASK_COUNT - 1)) ? '0 : p + t_ptr'(1);
    endfunction

endpackage

>>> sv/rmfh_if.sv
// ----------------------------------------------------------------------------
// Recursive mutex channels
// Request and response beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmfh_req_if import rmfh_pkg::*; ();
    logic valid;
    logic ready;
    logic func;
    t_id  task_id;

    modport source (output valid, output func, output task_id, input ready);
    modport sink   (input valid, input func, input task_id, output ready);
endinterface

interface rmfh_rsp_if import rmfh_pkg::*; ();
    logic       valid;
    logic       ready;
    t_status    status;
    t_id        woken_task;
    t_id        owner_task;
    t_depth_out lock_depth;
    t_wait_out  waiters;

    modport source (output valid, output status, output woken_task, output owner_task,
                    output lock_depth, output waiters, input ready);
    modport sink   (input valid, input status, input woken_task, input owner_task,
                    input lock_depth, input waiters, output ready);
endinterface

>>> sv/recursive_mutex_fifo_handoff.sv
// ----------------------------------------------------------------------------
// Recursive mutex with FIFO wait queue
// Lock/unlock requests, nesting count, queued waiters and direct handoff.
// ----------------------------------------------------------------------------
// One request beat is taken every cycle while the response side keeps up. A
// request lands in an input register and is resolved against the holder, the
// nesting count and the wait queue once the output register is free; its
// response beat is registered in that output register as it is resolved.
// The wait queue is a 64-entry memory whose head slot is read ahead into a
// register, so a handoff does not wait for a memory read. While a response
// waits to be taken, the input register can still take one more beat, and
// then the request side stalls. No clearing pass follows reset: the request
// side is ready at once.
module recursive_mutex_fifo_handoff
    import rmfh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmfh_req_if.sink   i_req,
    rmfh_rsp_if.source o_rsp
);

    logic       r_in_vld;
    logic       r_in_func;
    t_id        r_in_id;

    logic       r_out_vld;
    t_status    r_status;
    t_id        r_woken;
    t_id        r_owner;
    t_depth_out r_depth_out;
    t_wait_out  r_waiters;

    t_depth     r_count, n_count;
    t_id        r_holder, n_holder;
    t_ptr       r_head, n_head;
    t_ptr       r_tail, n_tail;
    t_fill      r_fill, n_fill;
    t_id        r_head_id;
    t_id        r_wait_mem [TASK_COUNT];

    t_status    n_status;
    t_id        n_woken;
    logic       wr_en;
    logic       advance;
    logic       in_take;

    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_comb begin
        n_count  = r_count;
        n_holder = r_holder;
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        n_status = ST_NOT_OWNER;
        n_woken  = '0;
        wr_en    = 1'b0;
        if (advance) begin
            if (r_in_func == FUNC_LOCK) begin
                if (r_count == '0) begin
                    n_count  = t_depth'(1);
                    n_holder = r_in_id;
                    n_status = ST_ACQUIRED;
                end else if (r_holder == r_in_id) begin
                    if (r_count == DEPTH_MAX) begin
                        n_status = ST_SATURATED;
                    end else begin
                        n_count  = r_count + t_depth'(1);
                        n_status = ST_NESTED;
                    end
                end else if (r_fill == FILL_FULL) begin
                    n_status = ST_QFULL;
                end else begin
                    wr_en    = 1'b1;
                    n_tail   = ptr_next(r_tail);
                    n_fill   = r_fill + t_fill'(1);
                    n_status = ST_QUEUED;
                end
            end else begin
                if (r_count == '0 || r_holder != r_in_id) begin
                    n_status = ST_NOT_OWNER;
                end else if (r_count != t_depth'(1)) begin
                    n_count  = r_count - t_depth'(1);
                    n_status = ST_PARTIAL;
                end else if (r_fill == '0) begin
                    n_count  = '0;
                    n_holder = '0;
                    n_status = ST_FREED;
                end else begin
                    n_head   = ptr_next(r_head);
                    n_fill   = r_fill - t_fill'(1);
                    n_holder = r_head_id;
                    n_count  = t_depth'(1);
                    n_woken  = r_head_id;
                    n_status = ST_HANDOFF;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_holder  <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            r_count  <= n_count;
            r_holder <= n_holder;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func <= i_req.func;
            r_in_id   <= i_req.task_id;
        end
        if (advance) begin
            r_status    <= n_status;
            r_woken     <= n_woken;
            r_owner     <= n_holder;
            r_depth_out <= DEPTH_OUT_W'(n_count);
            r_waiters   <= WAIT_OUT_W'(n_fill);
        end
    end

    // read ahead the head slot, bypass a write into it
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wait_mem[r_tail] <= r_in_id;
        end
        if (wr_en && r_tail == n_head) begin
            r_head_id <= r_in_id;
        end else begin
            r_head_id <= r_wait_mem[n_head];
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_status;
    assign o_rsp.woken_task = r_woken;
    assign o_rsp.owner_task = r_owner;
    assign o_rsp.lock_depth = r_depth_out;
    assign o_rsp.waiters    = r_waiters;

endmodule

>>> sv/rmfh_checker.sv
// ----------------------------------------------------------------------------
// Recursive mutex port checker
// Response timing and handoff/free consistency seen at the ports.
// ----------------------------------------------------------------------------
`include "recursive_mutex_fifo_handoff_assert.svh"

module rmfh_checker
    import rmfh_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input t_status    i_rsp_status,
    input t_id        i_rsp_woken,
    input t_id        i_rsp_owner,
    input t_depth_out i_rsp_depth,
    input t_wait_out  i_rsp_waiters
);

    `RMFH_CHECK_ALWAYS(a_reset_clears_rsp, i_clk, !i_rst_n |=> !i_rsp_valid)

    `RMFH_CHECK(a_rsp_holds, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_woken) && $stable(i_rsp_owner) && $stable(i_rsp_depth) && $stable(i_rsp_waiters))

    `RMFH_CHECK(a_rsp_latency, i_clk, i_rst_n, i_req_valid && i_req_ready && !i_rsp_valid |=> ##1 i_rsp_valid)

    `RMFH_CHECK(a_handoff_owner, i_clk, i_rst_n, i_rsp_valid && i_rsp_status == ST_HANDOFF |-> i_rsp_owner == i_rsp_woken && i_rsp_depth == DEPTH_OUT_W'(1))

    `RMFH_CHECK(a_freed_empty, i_clk, i_rst_n, i_rsp_valid && i_rsp_status == ST_FREED |-> i_rsp_owner == '0 && i_rsp_depth == '0 && i_rsp_waiters == '0)

endmodule

bind recursive_mutex_fifo_handoff rmfh_checker u_rmfh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_woken   (o_rsp.woken_task),
    .i_rsp_owner   (o_rsp.owner_task),
    .i_rsp_depth   (o_rsp.lock_depth),
    .i_rsp_waiters (o_rsp.waiters)
);
